// ===== hw/rtl/rlt_pkg.sv =====
// Shared types, register map codes and the count-to-level table
// for the resistance level tracker. No dependencies.
package rlt_pkg;

    localparam int LEVEL_ENTRIES = 16;
    localparam int TABLE_ROWS    = 16;
    localparam int MAP_ROWS      = (LEVEL_ENTRIES < TABLE_ROWS) ? LEVEL_ENTRIES : TABLE_ROWS;

    localparam int ADDR_W = 4;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_MOVE_TO  = 2'd1;
    localparam logic [1:0] REG_PAUSE_TO = 2'd2;

    localparam logic [15:0] DEBOUNCE_RST = 16'd10;
    localparam logic [15:0] MOVE_TO_RST  = 16'd500;
    localparam logic [15:0] PAUSE_TO_RST = 16'd2000;

    typedef struct packed {
        logic        forward_switch;
        logic        backward_switch;
        logic        limit_switch;
        logic        pulse_seen;
        logic [31:0] pulse_time_ms;
    } t_in;

    typedef struct packed {
        logic [4:0]  resistance_level;
        logic [15:0] position_count;
    } t_out;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] move_limit_ms;
        logic [15:0] pause_limit_ms;
    } t_cfg;

    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
        logic [4:0]  lvl;
    } t_span;

    localparam t_span LEVEL_SPANS [TABLE_ROWS] = '{
        '{16'd0,   16'd29,    5'd1},  '{16'd170, 16'd190, 5'd2},
        '{16'd281, 16'd308,   5'd3},  '{16'd360, 16'd374, 5'd4},
        '{16'd411, 16'd429,   5'd5},  '{16'd461, 16'd476, 5'd6},
        '{16'd501, 16'd519,   5'd7},  '{16'd531, 16'd549, 5'd8},
        '{16'd561, 16'd575,   5'd9},  '{16'd591, 16'd601, 5'd10},
        '{16'd611, 16'd627,   5'd11}, '{16'd631, 16'd641, 5'd12},
        '{16'd653, 16'd661,   5'd13}, '{16'd666, 16'd679, 5'd14},
        '{16'd681, 16'd690,   5'd15}, '{16'd692, 16'd65535, 5'd16}
    };

    // First matching row wins; a count in a gap keeps the old level.
    function automatic logic [4:0] map_level(input logic [15:0] count,
                                             input logic [4:0]  old_level);
        logic [4:0] lvl;
        lvl = old_level;
        for (int i = MAP_ROWS - 1; i >= 0; i--) begin
            if (count >= LEVEL_SPANS[i].lo && count <= LEVEL_SPANS[i].hi) begin
                lvl = LEVEL_SPANS[i].lvl;
            end
        end
        return lvl;
    endfunction

endpackage

// ===== hw/rtl/rlt_cfg.sv =====
// APB-style configuration registers of the resistance level tracker.
// Depends on rlt_pkg.
module rlt_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rlt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output rlt_pkg::t_cfg              o_cfg
);

    rlt_pkg::t_cfg r_cfg;
    logic [1:0]    idx;
    logic          wr;

    assign idx    = paddr[3:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms    <= rlt_pkg::DEBOUNCE_RST;
            r_cfg.move_limit_ms  <= rlt_pkg::MOVE_TO_RST;
            r_cfg.pause_limit_ms <= rlt_pkg::PAUSE_TO_RST;
        end else if (wr) begin
            case (idx)
                rlt_pkg::REG_DEBOUNCE: r_cfg.debounce_ms    <= pwdata[15:0];
                rlt_pkg::REG_MOVE_TO:  r_cfg.move_limit_ms  <= pwdata[15:0];
                rlt_pkg::REG_PAUSE_TO: r_cfg.pause_limit_ms <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            rlt_pkg::REG_DEBOUNCE: prdata = {16'd0, r_cfg.debounce_ms};
            rlt_pkg::REG_MOVE_TO:  prdata = {16'd0, r_cfg.move_limit_ms};
            rlt_pkg::REG_PAUSE_TO: prdata = {16'd0, r_cfg.pause_limit_ms};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

// ===== hw/rtl/rlt_core.sv =====
// Tracker state and per-poll update logic: pulse qualification, count step
// and level lookup. Depends on rlt_pkg.
module rlt_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rlt_pkg::t_cfg i_cfg,
    input  logic          i_fire,
    input  rlt_pkg::t_in  i_item,
    output rlt_pkg::t_out o_result
);

    logic [31:0] r_last_time, n_last_time;
    logic        r_prev_fwd,  n_prev_fwd;
    logic [15:0] r_count,     n_count;
    logic [4:0]  r_level,     n_level;

    logic        going_fwd, going_back, clr;
    logic [15:0] cnt0;
    logic [4:0]  lvl0;
    logic [31:0] gap;
    logic        take, steady, paused, step_up, step_dn;

    always_comb begin
        going_fwd  = i_item.forward_switch && !i_item.backward_switch;
        going_back = i_item.backward_switch && !i_item.forward_switch;
        clr        = !going_fwd && i_item.limit_switch;
        // limit clear happens before the pulse of the same poll
        cnt0       = clr ? 16'd0 : r_count;
        lvl0       = clr ? 5'd1 : r_level;

        gap    = i_item.pulse_time_ms - r_last_time;
        take   = i_item.pulse_seen && (gap > {16'd0, i_cfg.debounce_ms});
        steady = gap < {16'd0, i_cfg.move_limit_ms};
        paused = gap > {16'd0, i_cfg.pause_limit_ms};

        step_up = going_fwd && ((steady && r_prev_fwd) || paused) && (cnt0 != 16'hFFFF);
        step_dn = going_back && (cnt0 != 16'd0) && (paused || (steady && !r_prev_fwd));

        n_last_time = r_last_time;
        n_prev_fwd  = r_prev_fwd;
        n_count     = cnt0;
        n_level     = lvl0;
        if (take) begin
            n_last_time = i_item.pulse_time_ms;
            n_prev_fwd  = going_fwd;
            if (step_up) begin
                n_count = cnt0 + 16'd1;
            end else if (step_dn) begin
                n_count = cnt0 - 16'd1;
            end
            n_level = rlt_pkg::map_level(n_count, lvl0);
        end

        o_result.resistance_level = n_level;
        o_result.position_count   = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= 32'd0;
            r_prev_fwd  <= 1'b1;
            r_count     <= 16'd0;
            r_level     <= 5'd1;
        end else if (i_fire) begin
            r_last_time <= n_last_time;
            r_prev_fwd  <= n_prev_fwd;
            r_count     <= n_count;
            r_level     <= n_level;
        end
    end

endmodule

// ===== hw/rtl/resistance_level_tracker.sv =====
// Top level of the resistance level tracker: input register, output register
// and handshake. Depends on rlt_pkg, rlt_cfg and rlt_core.

// One poll in, one result out. A poll is held in an input register, updated
// combinationally against the tracker state and written to the output
// register, so a new poll can be taken every cycle unless the output
// register is full and not being read; a poll passes the input register and
// then the output register. The state update happens as the poll moves into
// the output register, so consecutive polls see each other's effects in order.
// Registers: 0x0 debounce time, 0x4 movement timeout, 0x8 pause timeout
// (16 bits each, milliseconds, low half of the word).
module resistance_level_tracker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  rlt_pkg::t_in               i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output rlt_pkg::t_out              o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rlt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    rlt_pkg::t_cfg cfg;
    rlt_pkg::t_in  r_item;
    logic          r_item_valid;
    rlt_pkg::t_out r_out;
    logic          r_out_valid;
    rlt_pkg::t_out result;
    logic          out_free, fire;

    assign out_free    = !r_out_valid || i_out_ready;
    assign fire        = r_item_valid && out_free;
    assign o_in_ready  = !r_item_valid || fire;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    rlt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rlt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (fire),
        .i_item   (r_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_item_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_item_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_in;
        end
        if (fire) begin
            r_out <= result;
        end
    end

endmodule
